FILE: rtl/core/simplified_aes_block_cipher_defines.svh
// Assertion helpers shared by the cipher RTL.
`ifndef SIMPLIFIED_AES_BLOCK_CIPHER_DEFINES_SVH
`define SIMPLIFIED_AES_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("saes assertion failed");

// Next-cycle implication, checked outside reset.
`define SAES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("saes assertion failed");

`endif

FILE: rtl/core/saes_pkg.sv
package saes_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned KeyW   = 16;

  localparam logic [7:0] RCON1 = 8'h80;
  localparam logic [7:0] RCON2 = 8'h30;

  localparam logic [3:0] ENC_MIX_A = 4'h1;
  localparam logic [3:0] ENC_MIX_B = 4'h4;
  localparam logic [3:0] DEC_MIX_A = 4'h9;
  localparam logic [3:0] DEC_MIX_B = 4'h2;

  localparam logic [0:0] MODE_ENC = 1'b0;
  localparam logic [0:0] MODE_DEC = 1'b1;

  localparam logic [3:0] FWD_SBOX [16] = '{
    4'h9, 4'h4, 4'ha, 4'hb, 4'hd, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hc, 4'he, 4'hf, 4'h7
  };
  localparam logic [3:0] INV_SBOX [16] = '{
    4'ha, 4'h5, 4'h9, 4'hb, 4'h1, 4'h7, 4'h8, 4'hf,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hc, 4'h4, 4'hd, 4'he
  };

  typedef struct packed {
    logic [KeyW-1:0] k0;
    logic [KeyW-1:0] k1;
    logic [KeyW-1:0] k2;
  } round_keys_t;

  // GF(16) multiply, modulus x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] r;
    logic [3:0] aa;
    r  = 4'h0;
    aa = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        r = r ^ aa;
      end
      aa = {aa[2:0], 1'b0} ^ (aa[3] ? 4'h3 : 4'h0);
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] x);
    return {FWD_SBOX[x[15:12]], FWD_SBOX[x[11:8]], FWD_SBOX[x[7:4]], FWD_SBOX[x[3:0]]};
  endfunction

  function automatic logic [BlockW-1:0] sub_inv(input logic [BlockW-1:0] x);
    return {INV_SBOX[x[15:12]], INV_SBOX[x[11:8]], INV_SBOX[x[7:4]], INV_SBOX[x[3:0]]};
  endfunction

  // swap n1 and n3
  function automatic logic [BlockW-1:0] shift_row(input logic [BlockW-1:0] x);
    return {x[15:12], x[3:0], x[7:4], x[11:8]};
  endfunction

  function automatic logic [BlockW-1:0] mix_col(input logic [BlockW-1:0] x,
                                                input logic [3:0] a,
                                                input logic [3:0] b);
    return {gf_mul(a, x[15:12]) ^ gf_mul(b, x[11:8]),
            gf_mul(b, x[15:12]) ^ gf_mul(a, x[11:8]),
            gf_mul(a, x[7:4])   ^ gf_mul(b, x[3:0]),
            gf_mul(b, x[7:4])   ^ gf_mul(a, x[3:0])};
  endfunction

  // rotate nibbles, then substitute
  function automatic logic [7:0] rot_sub(input logic [7:0] w);
    return {FWD_SBOX[w[3:0]], FWD_SBOX[w[7:4]]};
  endfunction

endpackage

FILE: rtl/core/saes_key_exp.sv
module saes_key_exp (
  input  logic [saes_pkg::KeyW-1:0] key_i,
  output saes_pkg::round_keys_t     rkeys_o
);

  logic [7:0] w0, w1, w2, w3, w4, w5;

  assign w0 = key_i[15:8];
  assign w1 = key_i[7:0];
  assign w2 = w0 ^ saes_pkg::RCON1 ^ saes_pkg::rot_sub(w1);
  assign w3 = w2 ^ w1;
  assign w4 = w2 ^ saes_pkg::RCON2 ^ saes_pkg::rot_sub(w3);
  assign w5 = w4 ^ w3;

  assign rkeys_o.k0 = key_i;
  assign rkeys_o.k1 = {w2, w3};
  assign rkeys_o.k2 = {w4, w5};

endmodule

FILE: rtl/core/simplified_aes_block_cipher.sv
// S-AES, 16-bit block, three-stage pipeline.
// A result reaches m_axis after passing through the x1_q, x2_q and x3_q registers in turn.
// Throughput: one block per cycle; each stage holds under backpressure.
// Reset (async, active low) empties the pipeline and clears the key to 0.
// Round keys are expanded from the key register without added latency.
module simplified_aes_block_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // key write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [saes_pkg::KeyW-1:0]   cfg_data_i,     // [15:0] cipher_key
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [saes_pkg::BlockW-1:0] s_axis_tdata_i, // [15:0] data_block
  input  logic                        s_axis_tuser_i, // [0] mode
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [saes_pkg::BlockW-1:0] m_axis_tdata_o  // [15:0] result_block
);

  logic [saes_pkg::KeyW-1:0] key_q;
  saes_pkg::round_keys_t     rk;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic m1_q, m2_q;
  logic [saes_pkg::BlockW-1:0] x1_d, x1_q, x2_d, x2_q, x3_d, x3_q;
  logic [saes_pkg::BlockW-1:0] t2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_q <= cfg_data_i;
    end
  end

  saes_key_exp u_key_exp (
    .key_i   (key_q),
    .rkeys_o (rk)
  );

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // stage 1: first key add, substitution and row shift
  always_comb begin
    if (s_axis_tuser_i == saes_pkg::MODE_DEC) begin
      x1_d = saes_pkg::sub_inv(saes_pkg::shift_row(s_axis_tdata_i ^ rk.k2));
    end else begin
      x1_d = saes_pkg::shift_row(saes_pkg::sub_fwd(s_axis_tdata_i ^ rk.k0));
    end
  end

  // stage 2: middle key add and column mix
  always_comb begin
    t2 = '0;
    if (m1_q == saes_pkg::MODE_DEC) begin
      t2   = x1_q ^ rk.k1;
      x2_d = saes_pkg::mix_col(t2, saes_pkg::DEC_MIX_A, saes_pkg::DEC_MIX_B);
    end else begin
      x2_d = saes_pkg::mix_col(x1_q, saes_pkg::ENC_MIX_A, saes_pkg::ENC_MIX_B) ^ rk.k1;
    end
  end

  // stage 3: final round
  always_comb begin
    if (m2_q == saes_pkg::MODE_DEC) begin
      x3_d = saes_pkg::sub_inv(saes_pkg::shift_row(x2_q)) ^ rk.k0;
    end else begin
      x3_d = saes_pkg::shift_row(saes_pkg::sub_fwd(x2_q)) ^ rk.k2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= x1_d;
      m1_q <= s_axis_tuser_i;
    end
    if (en2) begin
      x2_q <= x2_d;
      m2_q <= m1_q;
    end
    if (en3) begin
      x3_q <= x3_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = x3_q;

`include "simplified_aes_block_cipher_defines.svh"

  `SAES_ASSERT_NOW(a_stall_full, !s_axis_tready_o, v1_q && v2_q && v3_q && !m_axis_tready_i)
  `SAES_ASSERT_NEXT(a_s1_adv, v1_q && en2, v2_q)
  `SAES_ASSERT_NEXT(a_s2_adv, v2_q && en3, v3_q)
  `SAES_ASSERT_NEXT(a_in_taken, s_axis_tvalid_i && s_axis_tready_o, v1_q)

endmodule
